// File: sv/tss_pkg.sv
// Shared types and constants of the threshold split search block.
`timescale 1ns / 1ps
`default_nettype none
package tss_pkg;

   localparam int DEF_MAX_OBSERVATIONS = 4096;
   localparam int DEF_MAX_VARIABLES    = 16;
   localparam int QUEUE_DEPTH          = 4;

   localparam int CNT_W   = 13;
   localparam int SUM_W   = 28;
   localparam int LSUM_W  = 29;
   localparam int KEY_W   = 16;
   localparam int RESP_W  = 16;
   localparam int VAR_W   = 5;
   localparam int SCORE_W = 44;

   localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

   typedef enum logic [1:0] {
      CSR_TOTAL_COUNT = 2'd0,
      CSR_TOTAL_SUM   = 2'd1,
      CSR_MIN_CHILD   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CNT_W-1:0]        count;
      logic signed [SUM_W-1:0] sum;
      logic [CNT_W-1:0]        min_child;
   } cfg_type;

   typedef struct packed {
      logic                     has_cut;
      logic                     is_last;
      logic [CNT_W-1:0]         left_count;
      logic signed [LSUM_W-1:0] left_sum;
      logic [VAR_W-1:0]         variable;
      logic signed [KEY_W-1:0]  threshold;
   } job_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_PROD,
      B_DIFF,
      B_SQ0,
      B_SQ1,
      B_SQ2,
      B_DIVINIT,
      B_DIV,
      B_UPD,
      B_OUT
   } back_state_type;

endpackage
`default_nettype wire

// File: sv/threshold_split_search.sv
// Top level of the threshold split search block.
// Observations arrive on the req_ channel, one transaction each, every
// variable's observations in ascending key order with req_new_variable on
// the first. The transaction with req_last_item high produces exactly one
// rsp_ transaction carrying the winning variable, midpoint threshold and
// score of the best cut over all variables seen since the previous result.
// The csr_ port writes N, S and the minimum child size; it is always ready
// and must only be used while the block is idle.
// The front end takes one observation per cycle while the job queue has
// room. The back end scores each admissible cut in turn: setup
// products, a three-pass square on one 22x22 multiplier and a 44-step
// restoring divider, which sets the throughput for cut-bearing items.
// Items with no cut that are not last never enter the queue. The result is
// offered once the last item's job is scored, or popped if it has no cut.
// A stalled receiver holds the back end in its output state; the front end
// keeps accepting observations until the queue fills.
// Synchronous reset clears all search state and loads the register defaults
// N = 2, S = 0, minimum child size 1.
`timescale 1ns / 1ps
`default_nettype none
module threshold_split_search #(
   parameter int MAX_OBSERVATIONS = tss_pkg::DEF_MAX_OBSERVATIONS,
   parameter int MAX_VARIABLES    = tss_pkg::DEF_MAX_VARIABLES
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire signed [tss_pkg::RESP_W-1:0]    req_response,
   input  wire signed [tss_pkg::KEY_W-1:0]     req_key,
   input  wire                                 req_new_variable,
   input  wire                                 req_last_item,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic                                rsp_found,
   output logic [tss_pkg::VAR_W-1:0]           rsp_best_variable,
   output logic signed [tss_pkg::KEY_W-1:0]    rsp_threshold,
   output logic [tss_pkg::SCORE_W-1:0]         rsp_best_score,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire [1:0]                           csr_index,
   input  wire [tss_pkg::SUM_W-1:0]            csr_data
);
   import tss_pkg::*;

   cfg_type cfg_ff;
   job_type push_job, head;
   logic    push, pop, empty, full, accept;

   assign csr_ready = 1'b1;
   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   // Writes to an index past the register list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.count     <= CNT_W'(2);
         cfg_ff.sum       <= '0;
         cfg_ff.min_child <= CNT_W'(1);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TOTAL_COUNT: cfg_ff.count     <= csr_data[CNT_W-1:0];
            CSR_TOTAL_SUM:   cfg_ff.sum       <= csr_data;
            CSR_MIN_CHILD:   cfg_ff.min_child <= csr_data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   tss_front #(
      .MAX_OBSERVATIONS(MAX_OBSERVATIONS),
      .MAX_VARIABLES(MAX_VARIABLES)
   ) u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .accept(accept),
      .response(req_response), .key(req_key),
      .new_variable(req_new_variable), .last_item(req_last_item),
      .push(push), .job(push_job)
   );

   tss_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .push(push), .push_job(push_job),
      .pop(pop), .head(head), .empty(empty), .full(full)
   );

   tss_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .head(head), .empty(empty),
      .pop(pop), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .found(rsp_found), .best_variable(rsp_best_variable),
      .threshold(rsp_threshold), .best_score(rsp_best_score)
   );

endmodule
`default_nettype wire

// File: sv/tss_front.sv
// Front end: tracks running left statistics and classifies each observation.
`timescale 1ns / 1ps
`default_nettype none
module tss_front #(
   parameter int MAX_OBSERVATIONS = tss_pkg::DEF_MAX_OBSERVATIONS,
   parameter int MAX_VARIABLES    = tss_pkg::DEF_MAX_VARIABLES
) (
   input  wire                                clock,
   input  wire                                reset,
   input  tss_pkg::cfg_type                   cfg,
   input  wire                                accept,
   input  wire signed [tss_pkg::RESP_W-1:0]   response,
   input  wire signed [tss_pkg::KEY_W-1:0]    key,
   input  wire                                new_variable,
   input  wire                                last_item,
   output logic                               push,
   output tss_pkg::job_type                   job
);
   import tss_pkg::*;

   localparam logic [CNT_W-1:0] CNT_CAP =
      CNT_W'((MAX_OBSERVATIONS < 8191) ? MAX_OBSERVATIONS : 8191);
   localparam logic [VAR_W-1:0] VAR_CAP =
      VAR_W'((MAX_VARIABLES < 31) ? MAX_VARIABLES : 31);

   logic [CNT_W-1:0]         lc_ff, lc_in;
   logic signed [LSUM_W-1:0] ls_ff, ls_in;
   logic signed [KEY_W-1:0]  pk_ff, pk_in;
   logic [VAR_W-1:0]         vc_ff, vc_in;

   logic                     start;
   logic signed [CNT_W:0]    nr;
   logic                     cut_ok;
   logic [CNT_W-1:0]         lc_base;
   logic signed [LSUM_W-1:0] ls_base;
   logic signed [KEY_W:0]    key_sum;

   always_comb begin
      start   = new_variable || (vc_ff == '0);
      nr      = $signed({1'b0, cfg.count}) - $signed({1'b0, lc_ff});
      cut_ok  = !start && (key != pk_ff) && (lc_ff != '0) && (nr >= 1)
                && (lc_ff >= cfg.min_child)
                && (nr >= $signed({1'b0, cfg.min_child}));
      key_sum = KEY_W'(0) + ({pk_ff[KEY_W-1], pk_ff} + {key[KEY_W-1], key});

      job.has_cut    = cut_ok;
      job.is_last    = last_item;
      job.left_count = lc_ff;
      job.left_sum   = ls_ff;
      job.variable   = vc_ff;
      job.threshold  = key_sum[KEY_W:1];
      push           = accept && (cut_ok || last_item);

      lc_base = start ? '0 : lc_ff;
      ls_base = start ? '0 : ls_ff;
      lc_in   = (lc_base < CNT_CAP) ? lc_base + 1'b1 : lc_base;
      ls_in   = ls_base + LSUM_W'(response);
      vc_in   = (start && (vc_ff < VAR_CAP)) ? vc_ff + 1'b1 : vc_ff;
      pk_in   = key;
      if (last_item) begin
         lc_in = '0;
         ls_in = '0;
         vc_in = '0;
         pk_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lc_ff <= '0;
         ls_ff <= '0;
         pk_ff <= '0;
         vc_ff <= '0;
      end else if (accept) begin
         lc_ff <= lc_in;
         ls_ff <= ls_in;
         pk_ff <= pk_in;
         vc_ff <= vc_in;
      end
   end

endmodule
`default_nettype wire

// File: sv/tss_queue.sv
// Short FIFO of classified jobs between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module tss_queue #(
   parameter int DEPTH = tss_pkg::QUEUE_DEPTH
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  tss_pkg::job_type push_job,
   input  wire              pop,
   output tss_pkg::job_type head,
   output logic             empty,
   output logic             full
);
   import tss_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   job_type              slots_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ff, rd_ff;
   logic [PTR_W:0]       cnt_ff;

   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == (PTR_W+1)'(DEPTH));
   assign head  = slots_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (full && !pop) |-> !push) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop) else $error("queue underflow");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PTR_W+1)'(DEPTH)) else $error("queue count out of range");

endmodule
`default_nettype wire

// File: sv/tss_back.sv
// Back end: scores each cut with a shared multiplier and a bit-serial divider.
`timescale 1ns / 1ps
`default_nettype none
module tss_back (
   input  wire                                clock,
   input  wire                                reset,
   input  tss_pkg::cfg_type                   cfg,
   input  tss_pkg::job_type                   head,
   input  wire                                empty,
   output logic                               pop,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic                               found,
   output logic [tss_pkg::VAR_W-1:0]          best_variable,
   output logic signed [tss_pkg::KEY_W-1:0]   threshold,
   output logic [tss_pkg::SCORE_W-1:0]        best_score
);
   import tss_pkg::*;

   back_state_type state_ff, state_in;

   job_type                 job_ff;
   logic signed [42:0]      p1_ff;
   logic signed [41:0]      p2_ff;
   logic [25:0]             p3_ff;
   logic [42:0]             a_ff;
   logic [38:0]             q_ff;
   logic [85:0]             acc_ff;
   logic [38:0]             rem_ff;
   logic [43:0]             lo_ff;
   logic [SCORE_W-1:0]      quo_ff;
   logic [5:0]              cnt_ff;

   logic [SCORE_W-1:0]      bs_ff;
   logic [VAR_W-1:0]        bv_ff;
   logic signed [KEY_W-1:0] bt_ff;
   logic                    bf_ff;

   logic [21:0]             mul_a, mul_b;
   logic [43:0]             mul_p;
   logic signed [43:0]      d;
   logic [CNT_W-1:0]        nr;
   logic [41:0]             hi;
   logic [39:0]             trial;

   always_comb begin
      mul_a = a_ff[21:0];
      mul_b = a_ff[21:0];
      case (state_ff)
         B_SQ1:   mul_a = {1'b0, a_ff[42:22]};
         B_SQ2: begin
            mul_a = {1'b0, a_ff[42:22]};
            mul_b = {1'b0, a_ff[42:22]};
         end
         default: ;
      endcase
      mul_p = mul_a * mul_b;
      d     = 44'(p1_ff) - 44'(p2_ff);
      nr    = cfg.count - job_ff.left_count;
      hi    = acc_ff[85:44];
      trial = {rem_ff, lo_ff[43]};
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!empty) begin
               state_in = head.has_cut ? B_PROD : (head.is_last ? B_OUT : B_IDLE);
            end
         end
         B_PROD:    state_in = B_DIFF;
         B_DIFF:    state_in = B_SQ0;
         B_SQ0:     state_in = B_SQ1;
         B_SQ1:     state_in = B_SQ2;
         B_SQ2:     state_in = B_DIVINIT;
         B_DIVINIT: state_in = (hi >= {3'b0, q_ff}) ? B_UPD : B_DIV;
         B_DIV:     state_in = (cnt_ff == 6'(SCORE_W-1)) ? B_UPD : B_DIV;
         B_UPD:     state_in = job_ff.is_last ? B_OUT : B_IDLE;
         B_OUT:     state_in = rsp_ready ? B_IDLE : B_OUT;
         default:   state_in = B_IDLE;
      endcase
   end

   always_comb begin
      pop           = (state_ff == B_IDLE) && !empty;
      rsp_valid     = (state_ff == B_OUT);
      found         = bf_ff;
      best_variable = bv_ff;
      threshold     = bt_ff;
      best_score    = bs_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: job_ff <= head;
         B_PROD: begin
            p1_ff <= $signed({1'b0, cfg.count}) * job_ff.left_sum;
            p2_ff <= $signed({1'b0, job_ff.left_count}) * cfg.sum;
            p3_ff <= cfg.count * job_ff.left_count;
         end
         B_DIFF: begin
            a_ff <= d[43] ? 43'(-d) : d[42:0];
            q_ff <= p3_ff * nr;
         end
         B_SQ0: acc_ff <= 86'(mul_p);
         B_SQ1: acc_ff <= acc_ff + (86'(mul_p) << 23);
         B_SQ2: acc_ff <= acc_ff + (86'(mul_p) << 44);
         B_DIVINIT: begin
            rem_ff <= hi[38:0];
            lo_ff  <= acc_ff[43:0];
            cnt_ff <= '0;
            quo_ff <= SCORE_MAX;
         end
         B_DIV: begin
            if (trial >= {1'b0, q_ff}) begin
               rem_ff <= 39'(trial - {1'b0, q_ff});
               quo_ff <= {quo_ff[SCORE_W-2:0], 1'b1};
            end else begin
               rem_ff <= trial[38:0];
               quo_ff <= {quo_ff[SCORE_W-2:0], 1'b0};
            end
            lo_ff  <= {lo_ff[42:0], 1'b0};
            cnt_ff <= cnt_ff + 1'b1;
         end
         default: ;
      endcase
   end

   // Running best. A saturated score leaves quo_ff at all ones.
   always_ff @(posedge clock) begin
      if (reset) begin
         bs_ff <= '0;
         bv_ff <= '0;
         bt_ff <= '0;
         bf_ff <= 1'b0;
      end else if (state_ff == B_UPD) begin
         if (quo_ff > bs_ff) begin
            bs_ff <= quo_ff;
            bv_ff <= job_ff.variable;
            bt_ff <= job_ff.threshold;
            bf_ff <= 1'b1;
         end
      end else if ((state_ff == B_OUT) && rsp_ready) begin
         bs_ff <= '0;
         bv_ff <= '0;
         bt_ff <= '0;
         bf_ff <= 1'b0;
      end
   end

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV) |-> (q_ff != '0)) else $error("divide by zero");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV) |-> (rem_ff < q_ff)) else $error("remainder out of range");
   a_found_score: assert property (@(posedge clock) disable iff (reset)
      bf_ff == (bs_ff != '0)) else $error("found flag disagrees with score");

endmodule
`default_nettype wire
